// ===== src/stbs_pkg.sv =====
// Shared types and constants for the sorted-table binary search block.
`default_nettype none

package stbs_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 7;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SEARCH = 1'b1
  } command_e;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  typedef struct packed {
    command_e                       command;
    logic [5:0]                     position;
    logic signed [VALUE_WIDTH-1:0]  entry_value;
    logic signed [VALUE_WIDTH-1:0]  search_key;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [5:0] match_position;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_en;     // store a loaded entry
    logic start;     // set up bounds and key for a new search
    logic step;      // narrow the bounds after one probe
    logic load_out;  // capture the result
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic done;      // match seen or range empty
  } status_t;

endpackage

`default_nettype wire

// ===== src/stbs_datapath.sv =====
// Table memory, search bounds, probe compare and result register.
`default_nettype none

module stbs_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  stbs_pkg::ctrl_t                  ctrl_i,
  output stbs_pkg::status_t                status_o,
  input  stbs_pkg::in_item_t               in_data_i,
  input  logic                             cfg_we_i,
  input  logic [stbs_pkg::CNT_W-1:0]       cfg_wdata_i,
  output stbs_pkg::out_item_t              out_data_o
);

  logic [stbs_pkg::VALUE_WIDTH-1:0] mem [stbs_pkg::TABLE_DEPTH];

  logic [stbs_pkg::CNT_W-1:0]       cnt_q;
  logic [stbs_pkg::CNT_W-1:0]       cnt_clamp;
  logic [stbs_pkg::CNT_W-1:0]       lo_q, lo_d;
  logic [stbs_pkg::CNT_W-1:0]       hi_q, hi_d;
  logic [stbs_pkg::CNT_W:0]         sum;
  logic [stbs_pkg::IDX_W-1:0]       mid_q, mid_d;
  logic [stbs_pkg::VALUE_WIDTH-1:0] rdata_q;
  logic [stbs_pkg::VALUE_WIDTH-1:0] key_q;
  logic                             empty;
  logic                             match;
  logic                             greater;
  stbs_pkg::out_item_t              out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cfg_we_i) begin
      cnt_q <= cfg_wdata_i;
    end
  end

  assign cnt_clamp = (cnt_q > stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH)) ?
                     stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH) : cnt_q;

  assign empty   = (lo_q >= hi_q);
  assign match   = (rdata_q == key_q);
  assign greater = ($signed(key_q) > $signed(rdata_q));

  assign status_o.done = empty || match;

  // bounds kept as [lo, hi), hi exclusive
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (ctrl_i.start) begin
      lo_d = '0;
      hi_d = cnt_clamp;
    end else if (ctrl_i.step) begin
      if (greater) begin
        lo_d = stbs_pkg::CNT_W'({1'b0, mid_q}) + stbs_pkg::CNT_W'(1);
      end else begin
        hi_d = stbs_pkg::CNT_W'({1'b0, mid_q});
      end
    end
  end

  // mid = (lo + hi - 1) / 2; wraps harmlessly when the range is empty
  assign sum   = {1'b0, lo_d} + {1'b0, hi_d} - (stbs_pkg::CNT_W+1)'(1);
  assign mid_d = sum[stbs_pkg::IDX_W:1];

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    if (ctrl_i.start) begin
      key_q <= in_data_i.search_key;
    end
    if (ctrl_i.load_out) begin
      out_q.found          <= !empty && match;
      out_q.match_position <= (!empty && match) ? mid_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[in_data_i.position] <= in_data_i.entry_value;
    end
    rdata_q <= mem[mid_d];
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ===== src/stbs_ctrl.sv =====
// Control state machine: handshakes, search sequencing, output valid.
`default_nettype none

module stbs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  stbs_pkg::command_e  in_command_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  stbs_pkg::status_t   status_i,
  output stbs_pkg::ctrl_t     ctrl_o
);

  stbs_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             idle;

  assign out_free = !out_valid_q || out_ready_i;
  assign idle     = (state_q == stbs_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stbs_pkg::ST_IDLE: begin
        if (in_valid_i && in_command_i == stbs_pkg::CMD_SEARCH) begin
          state_d = stbs_pkg::ST_SEARCH;
        end
      end
      stbs_pkg::ST_SEARCH: begin
        if (status_i.done && out_free) begin
          state_d = stbs_pkg::ST_IDLE;
        end
      end
      default: state_d = stbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = idle;
    ctrl_o.wr_en    = idle && in_valid_i && in_command_i == stbs_pkg::CMD_LOAD;
    ctrl_o.start    = idle && in_valid_i && in_command_i == stbs_pkg::CMD_SEARCH;
    ctrl_o.step     = !idle && !status_i.done;
    ctrl_o.load_out = !idle && status_i.done && out_free;
  end

  always_comb begin
    if (ctrl_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stbs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== src/sorted_table_binary_search_top.sv =====
// Top level of the sorted-table binary search: controller plus datapath.
// Load item: written to the table at the accept edge; no result.
// Search item: bounds set and first entry read at the accept edge, then one probe per
//   cycle (at most 7 for 64 entries); the result is registered once the output is free.
// Throughput: one search in flight; the next item is taken the cycle after its result is
//   registered; loads are taken one per cycle.
// Reset (rst_ni low, async): controller idle, no result pending, entry_count 0.
`default_nettype none

module sorted_table_binary_search_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  stbs_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output stbs_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [stbs_pkg::CNT_W-1:0]    cfg_wdata_i
);

  // command and status bundles between the two halves
  stbs_pkg::ctrl_t   ctrl;
  stbs_pkg::status_t status;

  // Controller: owns the handshakes and sequences start / probe / result.
  stbs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (status),
    .ctrl_o       (ctrl)
  );

  // Datapath: table RAM, entry_count register, [lo, hi) bounds, probe
  // compare and the result register.
  stbs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (out_data_o)
  );

  // A captured result is presented on the next cycle.
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load_out |=> out_valid_o)
    else $error("captured result not presented");

  // An accepted search item blocks further input in the following cycle.
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.command == stbs_pkg::CMD_SEARCH)
    |=> !in_ready_o)
    else $error("input accepted during a search");

  // A miss always reports position zero.
  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.found) |-> (out_data_o.match_position == '0))
    else $error("miss with nonzero position");

  // Never a table write and a search start in the same cycle.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.wr_en && ctrl.start))
    else $error("write and search start together");

endmodule

`default_nettype wire

// ===== test/sorted_table_binary_search_top_tb.sv =====
// Testbench for the sorted-table binary search: loads and searches checked against a shadow table.
module sorted_table_binary_search_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stbs_pkg::*;

  // No item moving on either side for this long means the block is hung.
  localparam int STALL_LIMIT  = 2000;
  // Settle time before a count write and at the end.
  localparam int DRAIN_CYCLES = 20;
  localparam int ITEM_TARGET  = 600;
  // Beyond this many items, both sides run flat out.
  localparam int CALM_FROM    = 480;

  localparam logic signed [VALUE_WIDTH-1:0] MOST_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] MOST_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  in_item_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_item_t        out_data_o;
  logic             cfg_we_i    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;

  sorted_table_binary_search_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // Commands waiting for the driver, and search results the block still owes us.
  in_item_t  queued_cmds[$];
  out_item_t due_results[$];

  // Shadow of the block: table contents and entry_count, updated on accepted items
  // and register writes only.
  logic signed [VALUE_WIDTH-1:0] shadow_table[TABLE_DEPTH];
  logic [CNT_W-1:0]              shadow_count = '0;

  // What the stimulus side believes the table holds once all queued loads land;
  // search keys are drawn from it.
  logic signed [VALUE_WIDTH-1:0] plan_table[TABLE_DEPTH];

  int   issued_items = 0;
  int   mismatches   = 0;
  int   quiet_cycles = 0;
  int   in_gap       = 0;
  int   out_stall    = 0;
  logic allow_idle   = 1'b1;
  // Input item taken at the last rising edge; lets the driver move on at the falling edge.
  logic in_acc       = 1'b0;

  task automatic log_mismatch(input string what);
    $display("%0t MISMATCH %s", $realtime, what);
    mismatches++;
  endtask

  // Classic binary search over the shadow table, midpoint (left+right)/2.
  // A count above the depth searches the whole table; a count of zero probes nothing.
  function automatic out_item_t predict_search(input logic signed [VALUE_WIDTH-1:0] key);
    out_item_t res;
    int        lo, hi, mid, span;
    logic      hit;
    span = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
    lo   = 0;
    hi   = span - 1;
    hit  = 1'b0;
    res  = '0;
    while (!hit && lo <= hi) begin
      mid = (lo + hi) / 2;
      if (shadow_table[mid] == key) begin
        hit                = 1'b1;
        res.found          = 1'b1;
        res.match_position = mid[5:0];
      end else if (key > shadow_table[mid]) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return res;
  endfunction

  // Unused payload fields carry random bits so every input bit toggles.
  task automatic queue_load(input int pos, input logic signed [VALUE_WIDTH-1:0] val);
    in_item_t it;
    it.command     = CMD_LOAD;
    it.position    = pos[5:0];
    it.entry_value = val;
    it.search_key  = $urandom;
    queued_cmds.push_back(it);
    plan_table[pos] = val;
    issued_items++;
  endtask

  task automatic queue_search(input logic signed [VALUE_WIDTH-1:0] key);
    in_item_t it;
    it.command     = CMD_SEARCH;
    it.position    = 6'($urandom);
    it.entry_value = $urandom;
    it.search_key  = key;
    queued_cmds.push_back(it);
    issued_items++;
  endtask

  // Wait until every queued item is taken and every result is back, then let the
  // block settle; a trailing load gives no result to wait for.
  task automatic drain();
    while (queued_cmds.size() != 0 || in_valid_i || due_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // entry_count only changes while the block is idle.
  task automatic set_entry_count(input int unsigned value);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[CNT_W-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Driver: presents items at the falling edge; holds an item until it is taken.
  // Idle bursts on the input side, stall bursts on the result side,
  // none once allow_idle drops.
  always @(negedge clk_i) begin
    logic     nxt_valid;
    in_item_t nxt_data;
    nxt_valid = in_valid_i;
    nxt_data  = in_data_i;
    if (rst_ni && (!in_valid_i || in_acc)) begin
      nxt_valid = 1'b0;
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
      end else if (queued_cmds.size() != 0) begin
        if (allow_idle && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 11);
        end else begin
          nxt_valid = 1'b1;
          nxt_data  = queued_cmds.pop_front();
        end
      end
    end
    in_valid_i <= nxt_valid;
    in_data_i  <= nxt_data;

    if (out_stall > 0) begin
      out_stall = out_stall - 1;
      out_ready_i <= 1'b0;
    end else if (allow_idle && $urandom_range(0, 5) == 0) begin
      out_stall = $urandom_range(0, 11);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: samples at the rising edge. Register writes and loads update the
  // shadow; a search pushes its predicted result; each result is checked
  // against the oldest one due.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (cfg_we_i) shadow_count = cfg_wdata_i;
      if (out_valid_o && out_ready_i) begin
        if (due_results.size() == 0) begin
          log_mismatch($sformatf("result found=%0b pos=%0d with no search outstanding",
                                 out_data_o.found, out_data_o.match_position));
        end else begin
          want = due_results.pop_front();
          if (out_data_o.found !== want.found)
            log_mismatch($sformatf("found: got %0b, want %0b",
                                   out_data_o.found, want.found));
          if (out_data_o.match_position !== want.match_position)
            log_mismatch($sformatf("match_position: got %0d, want %0d",
                                   out_data_o.match_position, want.match_position));
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (in_data_i.command == CMD_LOAD) begin
          shadow_table[in_data_i.position] = in_data_i.entry_value;
        end else begin
          due_results.push_back(predict_search(in_data_i.search_key));
        end
      end
    end
    in_acc <= rst_ni && in_valid_i && in_ready_o;
  end

  // Watchdog: ends the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus. Every search only probes positions that were loaded: a count of N is set
  // only with positions 0..N-1 (at most the table depth) loaded before any search of that phase.
  initial begin
    logic signed [VALUE_WIDTH-1:0] key;
    int sorted_vals[$];
    int n, m, style, pick, searches, slot, phase;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Count of zero after reset: nothing probed, not found.
    queue_search('0);
    queue_search(MOST_NEG);
    // Small sorted table with both extremes; position 63 written for its bits.
    queue_load(0, MOST_NEG);
    queue_load(1, -5);
    queue_load(2, 7);
    queue_load(3, MOST_POS);
    queue_load(TABLE_DEPTH - 1, 32'h5A5A_5A5A);
    set_entry_count(4);
    queue_search(MOST_NEG);
    queue_search(-5);
    queue_search(7);
    queue_search(MOST_POS);
    queue_search('0);
    queue_search(MOST_NEG + 1);
    queue_search(MOST_POS - 1);
    // Out of order: the top value now sits at the first probe, so -5 is missed.
    queue_load(1, MOST_POS);
    queue_search(-5);
    queue_search(7);
    // Single entry table.
    set_entry_count(1);
    queue_search(MOST_NEG);
    queue_search(7);

    // Random phases: pick a count, load a sorted table, then search it.
    // First phases pin full depth, the largest count and zero.
    phase = 0;
    while (issued_items < ITEM_TARGET) begin
      if (issued_items > CALM_FROM) allow_idle = 1'b0;
      case (phase)
        0: n = TABLE_DEPTH;
        1: n = (1 << CNT_W) - 1;
        2: n = 0;
        default: begin
          pick = $urandom_range(0, 19);
          if (pick == 0)      n = 0;
          else if (pick == 1) n = TABLE_DEPTH;
          else if (pick == 2) n = $urandom_range(TABLE_DEPTH + 1, (1 << CNT_W) - 1);
          else if (pick == 3) n = 1;
          else if (pick <= 5) n = $urandom_range(17, TABLE_DEPTH - 1);
          else                n = $urandom_range(2, 16);
        end
      endcase
      phase++;
      set_entry_count(n);

      // Style 0: full range, 1: narrow range with many duplicates,
      // 2: extremes at both ends, 3: loaded top down.
      m     = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
      style = $urandom_range(0, 3);
      sorted_vals.delete();
      for (int i = 0; i < m; i++)
        sorted_vals.push_back((style == 1) ? int'($urandom_range(0, 40)) - 20 : int'($urandom));
      sorted_vals.sort();
      if (style == 2 && m > 0) begin
        sorted_vals[0]     = MOST_NEG;
        sorted_vals[m - 1] = MOST_POS;
      end
      for (int i = 0; i < m; i++) begin
        slot = (style == 3) ? m - 1 - i : i;
        queue_load(slot, sorted_vals[slot]);
      end

      // Mostly keys present in the table, some neighbors and extremes, some noise;
      // a stray load now and then leaves the table out of order.
      searches = $urandom_range(4, 16);
      for (int s = 0; s < searches; s++) begin
        if ($urandom_range(0, 15) == 0) queue_load($urandom_range(0, TABLE_DEPTH - 1), $urandom);
        pick = $urandom_range(0, 9);
        if (m > 0 && pick <= 5)
          key = plan_table[$urandom_range(0, m - 1)];
        else if (m > 0 && pick == 6)
          key = plan_table[$urandom_range(0, m - 1)] + ($urandom_range(0, 1) ? 1 : -1);
        else if (pick == 7)
          key = $urandom_range(0, 1) ? MOST_POS : MOST_NEG;
        else
          key = $urandom;
        queue_search(key);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
